FILE: src/tarm_pkg.sv
package tarm_pkg;

  // default build of the block
  localparam int DEF_MAX_RANK   = 4;
  localparam int DEF_DIM_BITS   = 8;
  localparam int DEF_OUT_DEPTH  = 1024;
  localparam int DEF_DATA_WIDTH = 16;

  // register file layout
  localparam int NUM_DIM_REGS = 4;
  localparam int RANK_W       = 3;
  localparam int DIM_REG_W    = 9;
  localparam int MASK_W       = 4;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 9;

  localparam logic [RANK_W-1:0]    RANK_RESET = RANK_W'(4);
  localparam logic [DIM_REG_W-1:0] DIM_RESET  = DIM_REG_W'(1);
  localparam logic [MASK_W-1:0]    MASK_RESET = '0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RANK = 3'd0,
    REG_DIM0 = 3'd1,
    REG_DIM1 = 3'd2,
    REG_DIM2 = 3'd3,
    REG_DIM3 = 3'd4,
    REG_MASK = 3'd5
  } cfg_reg_t;

endpackage

FILE: src/tarm_ram.sv
module tarm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/tensor_axis_reduce_min.sv
// Streaming min-reduction over selected axes of a tensor of up to MAX_RANK
// dimensions. Elements arrive on the in_ stream in row-major order, one per
// transfer; in_tuser marks the first element of a tensor and clears the
// coordinate counters. The sustained rate is one element per clock: the
// coordinate counters advance in the accept cycle, the output position is
// built by an index pipeline with one multiply-add stage per dimension, and
// the per-position minimum lives in a 1R1W store that is read, compared and
// written back with a one-entry forward from the previous write. Each element
// passes the index stages, then the write-back stage. One result leaves when
// the last element of a position has been folded in; out_tlast flags the
// final result of the tensor and out_tuser flags a position at or beyond
// OUT_DEPTH (value and index then read as zero, store untouched). The input
// stalls only in a cycle where a result must enter the output register while
// the previous one has not been taken. The store needs no clearing after
// reset: the first element of each position overwrites its entry. The cfg_
// port may be written only while no element is in flight.
module tensor_axis_reduce_min #(
  parameter int MAX_RANK   = tarm_pkg::DEF_MAX_RANK,
  parameter int DIM_BITS   = tarm_pkg::DEF_DIM_BITS,
  parameter int OUT_DEPTH  = tarm_pkg::DEF_OUT_DEPTH,
  parameter int DATA_WIDTH = tarm_pkg::DEF_DATA_WIDTH,
  localparam int ADDR_W      = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1,
  localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((DATA_WIDTH + ADDR_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wen,
  input  logic [tarm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tarm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_TDATA_W-1:0]            in_tdata,   // elem_value
  input  logic                             in_tuser,   // tensor_start
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [OUT_TDATA_W-1:0]           out_tdata,  // min_value, out_index
  output logic                             out_tlast,  // tensor_done
  output logic                             out_tuser   // capacity_error
);

  import tarm_pkg::*;

  localparam int EXT_W = DIM_BITS + 1;
  localparam int CMP_W = (EXT_W > DIM_REG_W) ? EXT_W : DIM_REG_W;
  localparam int T_W   = ADDR_W + EXT_W + 1;
  localparam logic [CMP_W-1:0] EXT_LIM = CMP_W'(1) << DIM_BITS;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]          value;
    logic                                  first;
    logic                                  last;
    logic                                  done;
    logic [MAX_RANK-1:0]                   kept;
    logic [MAX_RANK-1:0][DIM_BITS-1:0]     coord;
    logic [ADDR_W-1:0]                     idx;
    logic                                  ovf;
  } stage_t;

  // configuration registers
  logic [RANK_W-1:0]    rank_r;
  logic [DIM_REG_W-1:0] dim_r [NUM_DIM_REGS];
  logic [MASK_W-1:0]    mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RANK_RESET;
      for (int i = 0; i < NUM_DIM_REGS; i++) begin
        dim_r[i] <= DIM_RESET;
      end
      mask_r <= MASK_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_RANK: rank_r   <= cfg_wdata[RANK_W-1:0];
        REG_DIM0: dim_r[0] <= cfg_wdata;
        REG_DIM1: dim_r[1] <= cfg_wdata;
        REG_DIM2: dim_r[2] <= cfg_wdata;
        REG_DIM3: dim_r[3] <= cfg_wdata;
        REG_MASK: mask_r   <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // effective extents and axis roles
  logic [EXT_W-1:0]    ext [MAX_RANK];
  logic [MAX_RANK-1:0] mask_ext;
  logic [RANK_W-1:0]   rank_eff;
  logic [MAX_RANK-1:0] inuse;
  logic [MAX_RANK-1:0] red;
  logic [MAX_RANK-1:0] kept;

  for (genvar k = 0; k < MAX_RANK; k++) begin : g_dim
    if (k < NUM_DIM_REGS) begin : g_reg
      logic [CMP_W-1:0] raw;
      assign raw = CMP_W'(dim_r[k]);
      assign ext[k] = (raw == '0) ? EXT_W'(1) :
                      (raw > EXT_LIM) ? EXT_W'(EXT_LIM) : EXT_W'(raw);
    end else begin : g_one
      assign ext[k] = EXT_W'(1);
    end
    if (k < MASK_W) begin : g_mbit
      assign mask_ext[k] = mask_r[k];
    end else begin : g_mzero
      assign mask_ext[k] = 1'b0;
    end
  end

  always_comb begin
    if (rank_r == '0) begin
      rank_eff = RANK_W'(1);
    end else if (int'(rank_r) > MAX_RANK) begin
      rank_eff = RANK_W'(MAX_RANK);
    end else begin
      rank_eff = rank_r;
    end
    for (int k = 0; k < MAX_RANK; k++) begin
      inuse[k] = (k < int'(rank_eff));
    end
    red = mask_ext & inuse;
    if (red == '0) begin
      red = inuse;
    end
    kept = inuse & ~red;
  end

  // pipeline control
  logic   en;
  logic   in_xfer;
  logic   [MAX_RANK:0] vld_r;
  stage_t pl_r   [MAX_RANK+1];
  stage_t pl_nxt [MAX_RANK];
  stage_t pl0;
  logic   w_vld_r;
  stage_t w_pl_r;
  logic   out_vld_r;
  logic   out_vld_nxt;

  assign en        = !(w_vld_r && w_pl_r.last && out_vld_r && !out_tready);
  assign in_tready = en;
  assign in_xfer   = in_tvalid && en;

  // coordinate counters and per-element flags
  logic [MAX_RANK-1:0][DIM_BITS-1:0] cnt_r;
  logic [MAX_RANK-1:0][DIM_BITS-1:0] cnt_nxt;
  logic [MAX_RANK-1:0][DIM_BITS-1:0] c;
  logic [MAX_RANK-1:0]               at_end;
  logic                              first;
  logic                              last;
  logic                              done;

  always_comb begin
    logic carry;
    carry = 1'b1;
    first = 1'b1;
    last  = 1'b1;
    done  = 1'b1;
    for (int k = 0; k < MAX_RANK; k++) begin
      c[k]      = in_tuser ? '0 : cnt_r[k];
      at_end[k] = ({1'b0, c[k]} >= (ext[k] - EXT_W'(1)));
      if (inuse[k]) begin
        if (!at_end[k]) done = 1'b0;
        if (red[k]) begin
          if (c[k] != '0) first = 1'b0;
          if (!at_end[k]) last = 1'b0;
        end
      end
    end
    // advance innermost first, carry ripples outward
    for (int d = MAX_RANK - 1; d >= 0; d--) begin
      cnt_nxt[d] = c[d];
      if (inuse[d] && carry) begin
        if (at_end[d]) begin
          cnt_nxt[d] = '0;
        end else begin
          cnt_nxt[d] = c[d] + DIM_BITS'(1);
          carry      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_xfer) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    pl0       = '0;
    pl0.value = in_tdata[DATA_WIDTH-1:0];
    pl0.first = first;
    pl0.last  = last;
    pl0.done  = done;
    pl0.kept  = kept;
    pl0.coord = c;
  end

  // index pipeline, one multiply-add per dimension
  for (genvar p = 0; p < MAX_RANK; p++) begin : g_idx
    logic [ADDR_W+EXT_W-1:0] prod;
    logic [T_W-1:0]          sum;
    logic                    hit;
    assign prod = pl_r[p].idx * ext[p];
    assign sum  = T_W'(prod) + T_W'(pl_r[p].coord[p]);
    assign hit  = pl_r[p].kept[p] && (sum >= T_W'(OUT_DEPTH));
    always_comb begin
      pl_nxt[p]     = pl_r[p];
      pl_nxt[p].ovf = pl_r[p].ovf | hit;
      if (pl_r[p].kept[p] && !pl_r[p].ovf && !hit) begin
        pl_nxt[p].idx = sum[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      w_vld_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[MAX_RANK-1:0], in_tvalid};
      w_vld_r <= vld_r[MAX_RANK];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r[0] <= pl0;
      for (int p = 0; p < MAX_RANK; p++) begin
        pl_r[p+1] <= pl_nxt[p];
      end
      w_pl_r <= pl_r[MAX_RANK];
    end
  end

  // min store: read on entry to the write-back stage, write on exit
  logic [DATA_WIDTH-1:0]        rd_data;
  logic                         st_wen;
  logic signed [DATA_WIDTH-1:0] base;
  logic signed [DATA_WIDTH-1:0] m;
  logic                         fwd_vld_r;
  logic [ADDR_W-1:0]            fwd_addr_r;
  logic [DATA_WIDTH-1:0]        fwd_data_r;

  assign st_wen = en && w_vld_r && !w_pl_r.ovf;

  tarm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (OUT_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wen),
    .wr_addr (w_pl_r.idx),
    .wr_data (m),
    .rd_en   (en),
    .rd_addr (pl_r[MAX_RANK].idx),
    .rd_data (rd_data)
  );

  // the write of the previous element lands at the same edge as this read
  always_comb begin
    base = (fwd_vld_r && fwd_addr_r == w_pl_r.idx) ? fwd_data_r : rd_data;
    m    = (!w_pl_r.first && base < w_pl_r.value) ? base : w_pl_r.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (st_wen) begin
      fwd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_wen) begin
      fwd_addr_r <= w_pl_r.idx;
      fwd_data_r <= m;
    end
  end

  // output register
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_last_r;
  logic                   out_user_r;

  always_comb begin
    out_vld_nxt = out_vld_r && !out_tready;
    if (en && w_vld_r && w_pl_r.last) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && w_vld_r && w_pl_r.last) begin
      out_data_r <= w_pl_r.ovf ? '0 : OUT_TDATA_W'({w_pl_r.idx, m});
      out_last_r <= w_pl_r.done;
      out_user_r <= w_pl_r.ovf;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: src/tarm_chk.sv
module tarm_chk #(
  parameter int OUT_TDATA_W = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // a pending result holds until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before transfer");

  // an out-of-capacity result carries zero value and index
  a_cap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("capacity error with nonzero payload");

  // input only backs up behind a result that is not taken
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

endmodule

bind tensor_axis_reduce_min tarm_chk #(
  .OUT_TDATA_W (OUT_TDATA_W)
) u_tarm_chk (.*);

FILE: bench/testbench.sv
module testbench;
  import tarm_pkg::*;

  localparam int IN_W       = ((DEF_DATA_WIDTH + 7) / 8) * 8;
  localparam int POS_W      = $clog2(DEF_OUT_DEPTH);
  localparam int OUT_W      = ((DEF_DATA_WIDTH + POS_W + 7) / 8) * 8;
  localparam int SETTLE_CYC = DEF_MAX_RANK + 3 + 5;
  localparam int CYCLE_CAP  = 500000;
  localparam int RAND_ITEMS = 1800;

  typedef struct packed {
    logic [DEF_DATA_WIDTH-1:0] value;
    logic                      start;
  } elem_t;

  typedef struct packed {
    logic [DEF_DATA_WIDTH-1:0] min_v;
    logic [POS_W-1:0]          pos;
    logic                      done;
    logic                      cap_err;
  } min_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wen = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_RANK;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;   // elem_value
  logic                  in_tuser = 1'b0; // tensor_start
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;       // min_value, out_index
  logic                  out_tlast;       // tensor_done
  logic                  out_tuser;       // capacity_error

  tensor_axis_reduce_min u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirror of the block: registers, coordinates and per-position minima
  logic [RANK_W-1:0]    rank_reg = RANK_RESET;
  logic [DIM_REG_W-1:0] dim_reg [NUM_DIM_REGS] = '{default: DIM_RESET};
  logic [MASK_W-1:0]    mask_reg = MASK_RESET;
  int unsigned          coord [DEF_MAX_RANK] = '{default: 0};
  logic [DEF_DATA_WIDTH-1:0] min_mirror [DEF_OUT_DEPTH] = '{default: '0};

  elem_t       elem_queue [$];
  min_result_t expected_mins [$];
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int          gap_mode = 0;
  logic        in_acc = 1'b0;

  function automatic int unsigned used_rank(logic [RANK_W-1:0] r);
    if (r == 0) return 1;
    if (r > DEF_MAX_RANK) return DEF_MAX_RANK;
    return r;
  endfunction

  function automatic int unsigned clamp_extent(logic [DIM_REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > (1 << DEF_DIM_BITS)) return 1 << DEF_DIM_BITS;
    return r;
  endfunction

  // fold one element into the mirrored store, queue the minimum it completes
  function automatic void fold_element(logic [DEF_DATA_WIDTH-1:0] value, logic start);
    int unsigned rk, msk, ext, k, d;
    longint unsigned pos;
    bit first_hit, last_hit, done, ovf, at_end;
    logic [DEF_DATA_WIDTH-1:0] m;
    min_result_t res;
    rk = used_rank(rank_reg);
    msk = mask_reg & ((1 << rk) - 1);
    if (msk == 0) msk = (1 << rk) - 1;
    if (start) for (k = 0; k < DEF_MAX_RANK; k++) coord[k] = 0;
    first_hit = 1; last_hit = 1; done = 1; ovf = 0; pos = 0; m = value;
    for (k = 0; k < rk; k++) begin
      ext = clamp_extent(dim_reg[k]);
      at_end = (coord[k] >= ext - 1);
      if (!at_end) done = 0;
      if ((msk >> k) & 1) begin
        if (coord[k] != 0) first_hit = 0;
        if (!at_end) last_hit = 0;
      end else begin
        pos = pos * ext + coord[k];
        if (pos >= DEF_OUT_DEPTH) ovf = 1;
      end
    end
    if (!ovf) begin
      if (!first_hit && $signed(min_mirror[pos]) < $signed(m)) m = min_mirror[pos];
      min_mirror[pos] = m;
    end
    if (last_hit) begin
      res.min_v   = ovf ? '0 : m;
      res.pos     = ovf ? '0 : pos[POS_W-1:0];
      res.done    = done;
      res.cap_err = ovf;
      expected_mins.push_back(res);
    end
    // advance innermost first, anything at or past its extent wraps
    k = rk;
    while (k > 0) begin
      d = k - 1;
      ext = clamp_extent(dim_reg[d]);
      if (coord[d] >= ext - 1) begin
        coord[d] = 0;
        k--;
      end else begin
        coord[d] = (coord[d] + 1) & ((1 << DEF_DIM_BITS) - 1);
        break;
      end
    end
  endfunction

  // input side: hold an unaccepted transfer, otherwise maybe idle
  always @(negedge clk) begin
    elem_t nxt;
    bit idle_now;
    idle_now = (gap_mode == 1 && $urandom_range(99) < 46) ||
               (gap_mode == 3 && $urandom_range(99) < 36);
    if (!(in_tvalid && !in_acc)) begin
      if (rst_n && elem_queue.size() > 0 && !idle_now) begin
        nxt = elem_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= IN_W'(nxt.value);
        in_tuser  <= nxt.start;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= !((gap_mode == 2 && $urandom_range(99) < 46) ||
                    (gap_mode == 3 && $urandom_range(99) < 36));
  end

  always @(posedge clk) begin
    min_result_t want;
    in_acc <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      fold_element(in_tdata[DEF_DATA_WIDTH-1:0], in_tuser);
      accepted_count++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_mins.size() == 0) begin
        $error("result transfer with nothing expected: tdata %h", out_tdata);
        err_count++;
      end else begin
        want = expected_mins.pop_front();
        if (out_tdata[DEF_DATA_WIDTH-1:0] !== want.min_v) begin
          $error("min_value: expected %h, got %h", want.min_v,
                 out_tdata[DEF_DATA_WIDTH-1:0]);
          err_count++;
        end
        if (out_tdata[DEF_DATA_WIDTH +: POS_W] !== want.pos) begin
          $error("out_index: expected %0d, got %0d", want.pos,
                 out_tdata[DEF_DATA_WIDTH +: POS_W]);
          err_count++;
        end
        if (out_tlast !== want.done) begin
          $error("tensor_done: expected %b, got %b", want.done, out_tlast);
          err_count++;
        end
        if (out_tuser !== want.cap_err) begin
          $error("capacity_error: expected %b, got %b", want.cap_err, out_tuser);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("** tensor_axis_reduce_min: FAILED **");
      $finish;
    end
  end

  task automatic settle();
    do @(negedge clk);
    while (accepted_count != queued_count || expected_mins.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    case (r)
      REG_RANK: rank_reg = v[RANK_W-1:0];
      REG_DIM0: dim_reg[0] = v;
      REG_DIM1: dim_reg[1] = v;
      REG_DIM2: dim_reg[2] = v;
      REG_DIM3: dim_reg[3] = v;
      REG_MASK: mask_reg = v[MASK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic push_elem(logic [DEF_DATA_WIDTH-1:0] v, logic s);
    elem_queue.push_back('{value: v, start: s});
    queued_count++;
  endtask

  initial begin
    logic [DEF_DATA_WIDTH-1:0] corner_vals [4];
    logic [DIM_REG_W-1:0] dims [NUM_DIM_REGS];
    logic [RANK_W-1:0] rank_val;
    logic [DEF_DATA_WIDTH-1:0] v;
    int unsigned r, odd_dim, tsize, len, i, k, phase_items, rand_items, phase_no;
    bit prev_complete, s;

    corner_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 3x3, reduce the inner axis: one minimum per row, corner values
    write_reg(REG_RANK, 9'd2);
    write_reg(REG_DIM0, 9'd3);
    write_reg(REG_DIM1, 9'd3);
    write_reg(REG_DIM2, 9'd0);
    write_reg(REG_DIM3, 9'd511);
    write_reg(REG_MASK, 9'b0010);
    push_elem(16'h7FFF, 1); push_elem(16'h8000, 0); push_elem(16'h0000, 0);
    push_elem(16'hFFFF, 0); push_elem(16'h0001, 0); push_elem(16'h8001, 0);
    push_elem(16'h7FFE, 0); push_elem(16'h7FFF, 0); push_elem(16'h1234, 0);
    settle();

    // walk the outer axis to 4, then widen the next axis so positions overflow
    write_reg(REG_DIM0, 9'd256);
    write_reg(REG_DIM1, 9'd1);
    write_reg(REG_MASK, 9'b1110);
    push_elem(16'h0042, 1); push_elem(16'hFF00, 0);
    push_elem(16'h0100, 0); push_elem(16'h8000, 0);
    settle();
    write_reg(REG_RANK, 9'd3);
    write_reg(REG_DIM1, 9'd256);
    write_reg(REG_DIM2, 9'd1);
    write_reg(REG_MASK, 9'b0100);
    push_elem(16'h1111, 0); push_elem(16'h8888, 0); push_elem(16'h7FFF, 0);
    settle();

    // shrink under live counters: they sit past their extents and wrap
    write_reg(REG_RANK, 9'd2);
    write_reg(REG_DIM0, 9'd2);
    write_reg(REG_DIM1, 9'd2);
    write_reg(REG_MASK, 9'b0000);
    push_elem(16'h0005, 0); push_elem(16'hC000, 0); push_elem(16'h0003, 0);
    settle();

    // rank zero behaves as one, rank seven as four
    write_reg(REG_RANK, 9'd0);
    write_reg(REG_DIM0, 9'd3);
    push_elem(16'h0200, 1); push_elem(16'h0100, 0); push_elem(16'h0300, 0);
    settle();
    write_reg(REG_RANK, 9'd7);
    write_reg(REG_DIM0, 9'd2);
    write_reg(REG_DIM1, 9'd1);
    write_reg(REG_DIM3, 9'd0);
    write_reg(REG_MASK, 9'b1000);
    push_elem(16'hABCD, 1); push_elem(16'h5432, 0);

    rand_items = 0;
    phase_no = 0;
    while (rand_items < RAND_ITEMS) begin
      settle();
      gap_mode = phase_no % 4;
      phase_no++;
      r = $urandom_range(0, 9);
      if (r == 0) rank_val = 0;
      else if (r == 9) rank_val = $urandom_range(5, 7);
      else rank_val = ((r - 1) % 4) + 1;
      for (k = 0; k < NUM_DIM_REGS; k++) dims[k] = $urandom_range(1, 5);
      if ($urandom_range(4) == 0) begin
        odd_dim = $urandom_range(0, NUM_DIM_REGS - 1);
        case ($urandom_range(3))
          0: dims[odd_dim] = 0;
          1: dims[odd_dim] = 256;
          2: dims[odd_dim] = $urandom_range(257, 511);
          default: dims[odd_dim] = $urandom_range(6, 40);
        endcase
        tsize = 1;
        for (k = 0; k < used_rank(rank_val); k++) tsize *= clamp_extent(dims[k]);
        if (tsize > 600)
          for (k = 0; k < NUM_DIM_REGS; k++) if (k != odd_dim) dims[k] = 1;
      end
      write_reg(REG_RANK, 9'(rank_val));
      write_reg(REG_DIM0, dims[0]);
      write_reg(REG_DIM1, dims[1]);
      write_reg(REG_DIM2, dims[2]);
      write_reg(REG_DIM3, dims[3]);
      write_reg(REG_MASK, 9'($urandom_range(0, 15)));
      tsize = 1;
      for (k = 0; k < used_rank(rank_reg); k++) tsize *= clamp_extent(dim_reg[k]);

      // mostly whole tensors; some cut short, some restarted midway
      phase_items = 0;
      prev_complete = 0;
      while (phase_items < 40) begin
        len = tsize;
        if (tsize > 1 && $urandom_range(9) == 0) len = $urandom_range(1, tsize - 1);
        for (i = 0; i < len; i++) begin
          if (i == 0) s = !(prev_complete && $urandom_range(7) == 0);
          else s = ($urandom_range(49) == 0);
          if ($urandom_range(15) == 0) v = corner_vals[$urandom_range(3)];
          else v = DEF_DATA_WIDTH'($urandom);
          push_elem(v, s);
        end
        prev_complete = (len == tsize);
        phase_items += len;
      end
      rand_items += phase_items;
    end

    settle();
    if (err_count == 0) begin
      $display("** tensor_axis_reduce_min: PASSED **");
    end else begin
      $display("** tensor_axis_reduce_min: FAILED **");
    end
    $finish;
  end

endmodule

FILE: tensor_axis_reduce_min.f
src/tarm_pkg.sv
src/tarm_ram.sv
src/tensor_axis_reduce_min.sv
src/tarm_chk.sv
bench/testbench.sv
